>>> hdl/keyed_case_mask_set_table_top_assert.svh
// Assertion macros for the keyed case-mask set table.
`ifndef KEYED_CASE_MASK_SET_TABLE_TOP_ASSERT_SVH
`define KEYED_CASE_MASK_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCMST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCMST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/kcmst_pkg.sv
// Shared constants, codes and types of the keyed case-mask set table.
package kcmst_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BITS    = 16;
	localparam int MASK_BITS   = 64;

	// Field widths of the request and response items
	localparam int OP_W     = 3;
	localparam int KEY_W    = 16;
	localparam int CIDX_W   = 6;
	localparam int MASK_W   = 64;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_ADD_CASE = 3'd1,
		OP_ADD_ALL  = 3'd2,
		OP_MERGE    = 3'd3,
		OP_REMOVE   = 3'd4,
		OP_LOOKUP   = 3'd5,
		OP_SUBSET   = 3'd6
	} kcmst_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_FULL   = 2'd1,
		ST_ABSENT = 2'd2
	} kcmst_status_t;

	// Broadcast from the controller to every cell
	typedef struct packed {
		logic                 search;
		logic                 clear_all;
		logic                 wr_hit;
		logic                 wr_new;
		logic                 del_hit;
		logic [KEY_BITS-1:0]  key;
		logic [MASK_BITS-1:0] mask;
	} kcmst_cmd_t;

	// Per-cell flags seen by the controller
	typedef struct packed {
		logic valid;
		logic sel_hit;
		logic sel_free;
	} kcmst_cell_st_t;

endpackage

>>> hdl/kcmst_req_if.sv
// Request channel: one table operation per item.
interface kcmst_req_if;
	import kcmst_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [KEY_W-1:0]  type_key;
	logic [CIDX_W-1:0] case_pos;
	logic [MASK_W-1:0] case_bits;
	logic              last;

	modport source (output valid, operation, type_key, case_pos, case_bits, last,
		input ready);
	modport sink (input valid, operation, type_key, case_pos, case_bits, last,
		output ready);
endinterface

>>> hdl/kcmst_rsp_if.sv
// Response channel: one result item per request item.
interface kcmst_rsp_if;
	import kcmst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [MASK_W-1:0]   stored_mask;
	logic                subset_result;
	logic                subset_done;

	modport source (output valid, status, found, stored_mask, subset_result, subset_done,
		input ready);
	modport sink (input valid, status, found, stored_mask, subset_result, subset_done,
		output ready);
endinterface

>>> hdl/keyed_case_mask_set_table_top.sv
// Top level of the keyed case-mask set table: controller, cell chain and result register.
//
//   port  role    carries
//   req   sink    operation, type_key, case_pos, case_bits, last
//   rsp   source  status, found, stored_mask, subset_result, subset_done
//
// Each item passes through a search state over the cell chain (key match and first
// free slot), then an update state that read-modify-writes the selected cell and loads the result.
// The next item is taken in the update cycle, so its search can start while the last result waits.
// A result waiting in the output register holds the update cycle until it is taken.
// Reset empties the table and sets the running subset verdict; no clearing pass.
module keyed_case_mask_set_table_top (
	input logic  clk,
	input logic  arst_n,
	kcmst_req_if.sink   req,
	kcmst_rsp_if.source rsp
);
	import kcmst_pkg::*;

	`include "keyed_case_mask_set_table_top_assert.svh"

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_UPDATE = 3'b100
	} state_t;

	state_t state_q;

	logic [OP_W-1:0]      op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CIDX_W-1:0]    cidx_q;
	logic [MASK_BITS-1:0] mask_q;
	logic                 last_q;

	logic                 found_s1;
	logic                 full_s1;
	logic [MASK_BITS-1:0] old_s1;

	logic                 run_q;

	logic                 out_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic                 found_q;
	logic [MASK_BITS-1:0] stored_q;
	logic                 result_q;
	logic                 done_q;

	logic accept;
	logic commit;

	kcmst_cmd_t           cmd;
	logic [TABLE_DEPTH:0] hit_c;
	logic [TABLE_DEPTH:0] free_c;
	logic [MASK_BITS-1:0] mask_c [TABLE_DEPTH+1];
	kcmst_cell_st_t       cell_st [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_v;
	logic [TABLE_DEPTH-1:0] hit_v;
	logic [TABLE_DEPTH-1:0] free_v;

	// Update-cycle decisions
	logic                 cidx_ok;
	logic [MASK_BITS-1:0] case_bit;
	logic [MASK_BITS-1:0] new_mask;
	logic [MASK_BITS-1:0] rem_mask;
	logic                 cover_ok;
	logic                 verdict;
	logic                 run_next;
	logic [STATUS_W-1:0]  status_d;
	logic                 found_d;
	logic [MASK_BITS-1:0] stored_d;
	logic                 done_d;
	logic                 wr_hit_d;
	logic                 wr_new_d;
	logic                 del_hit_d;
	logic                 clear_d;

	assign commit    = (state_q == S_UPDATE) && (!out_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE) || commit;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (accept) state_q <= S_SEARCH;
					else if (commit) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.operation;
			key_q  <= req.type_key[KEY_BITS-1:0];
			cidx_q <= req.case_pos;
			mask_q <= req.case_bits[MASK_BITS-1:0];
			last_q <= req.last;
		end
		if (state_q == S_SEARCH) begin
			found_s1 <= hit_c[TABLE_DEPTH];
			full_s1  <= !free_c[TABLE_DEPTH];
			old_s1   <= mask_c[TABLE_DEPTH];
		end
	end

	// Cell chain
	assign hit_c[0]  = 1'b0;
	assign free_c[0] = 1'b0;
	assign mask_c[0] = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		kcmst_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.hit_in   (hit_c[g]),
			.free_in  (free_c[g]),
			.mask_in  (mask_c[g]),
			.hit_out  (hit_c[g+1]),
			.free_out (free_c[g+1]),
			.mask_out (mask_c[g+1]),
			.st       (cell_st[g])
		);
	end

	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			valid_v[i] = cell_st[i].valid;
			hit_v[i]   = cell_st[i].sel_hit;
			free_v[i]  = cell_st[i].sel_free;
		end
	end

	assign cidx_ok  = ({1'b0, cidx_q} < (CIDX_W+1)'(MASK_BITS));
	assign case_bit = MASK_BITS'(1) << cidx_q;
	assign rem_mask = old_s1 & ~mask_q;
	assign cover_ok = found_s1 &&
		((old_s1 == '0) || ((mask_q != '0) && ((mask_q & old_s1) == mask_q)));

	always_comb begin
		status_d  = ST_DONE;
		found_d   = found_s1;
		stored_d  = '0;
		done_d    = 1'b0;
		verdict   = run_q;
		new_mask  = '0;
		wr_hit_d  = 1'b0;
		wr_new_d  = 1'b0;
		del_hit_d = 1'b0;
		clear_d   = 1'b0;
		case (op_q)
			OP_CLEAR: begin
				clear_d = 1'b1;
				verdict = 1'b1;
			end
			OP_ADD_CASE, OP_ADD_ALL, OP_MERGE: begin
				if (op_q == OP_ADD_CASE && !cidx_ok) begin
					stored_d = found_s1 ? old_s1 : '0;
				end else if (found_s1) begin
					if (op_q == OP_ADD_CASE)
						new_mask = (old_s1 == '0) ? '0 : (old_s1 | case_bit);
					else if (op_q == OP_MERGE)
						new_mask = (old_s1 == '0 || mask_q == '0) ? '0 : (old_s1 | mask_q);
					else
						new_mask = '0;
					wr_hit_d = 1'b1;
					stored_d = new_mask;
				end else if (full_s1) begin
					status_d = ST_FULL;
				end else begin
					if (op_q == OP_ADD_CASE)
						new_mask = case_bit;
					else if (op_q == OP_MERGE)
						new_mask = mask_q;
					else
						new_mask = '0;
					wr_new_d = 1'b1;
					stored_d = new_mask;
				end
			end
			OP_REMOVE: begin
				if (!found_s1) begin
					status_d = ST_ABSENT;
				end else if (mask_q == '0 || rem_mask == '0) begin
					del_hit_d = 1'b1;
				end else begin
					new_mask = rem_mask;
					wr_hit_d = 1'b1;
					stored_d = rem_mask;
				end
			end
			OP_LOOKUP: begin
				if (!found_s1) status_d = ST_ABSENT;
				else stored_d = old_s1;
			end
			OP_SUBSET: begin
				if (!found_s1) status_d = ST_ABSENT;
				else stored_d = old_s1;
				verdict = run_q && cover_ok;
				done_d  = last_q;
			end
			default: begin
				found_d = 1'b0;
			end
		endcase
		run_next = done_d ? 1'b1 : verdict;
	end

	always_comb begin
		cmd.search    = (state_q == S_SEARCH);
		cmd.clear_all = commit && clear_d;
		cmd.wr_hit    = commit && wr_hit_d;
		cmd.wr_new    = commit && wr_new_d;
		cmd.del_hit   = commit && del_hit_d;
		cmd.key       = key_q;
		cmd.mask      = new_mask;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				run_q       <= run_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= status_d;
			found_q  <= found_d;
			stored_q <= stored_d;
			result_q <= verdict;
			done_q   <= done_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.found         = found_q;
	assign rsp.stored_mask   = MASK_W'(stored_q);
	assign rsp.subset_result = result_q;
	assign rsp.subset_done   = done_q;

	`KCMST_ASSERT_NOW(a_one_hit, clk, arst_n, state_q == S_UPDATE, $onehot0(hit_v), "more than one cell claims the key")
	`KCMST_ASSERT_NOW(a_one_free, clk, arst_n, state_q == S_UPDATE, $onehot0(free_v), "more than one cell claims the free slot")
	`KCMST_ASSERT_NOW(a_full_no_free, clk, arst_n, state_q == S_UPDATE && full_s1, free_v == '0, "full table with a free cell selected")
	`KCMST_ASSERT_NEXT(a_search_update, clk, arst_n, state_q == S_SEARCH, state_q == S_UPDATE && out_valid_q == $past(out_valid_q && !rsp.ready), "search not followed by update")
	`KCMST_ASSERT_NEXT(a_clear_empties, clk, arst_n, commit && clear_d, valid_v == '0 && run_q, "clear left an entry valid")
endmodule

>>> hdl/kcmst_cell.sv
// One table entry: key compare, priority hand-off to the next cell and entry update.
module kcmst_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kcmst_pkg::kcmst_cmd_t          cmd,
	input  logic                           hit_in,
	input  logic                           free_in,
	input  logic [kcmst_pkg::MASK_BITS-1:0] mask_in,
	output logic                           hit_out,
	output logic                           free_out,
	output logic [kcmst_pkg::MASK_BITS-1:0] mask_out,
	output kcmst_pkg::kcmst_cell_st_t      st
);
	import kcmst_pkg::*;

	logic                 valid_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [MASK_BITS-1:0] mask_q;
	logic                 sel_hit_s1;
	logic                 sel_free_s1;
	logic                 my_hit;
	logic                 sel_hit;
	logic                 sel_free;

	// The first matching and the first empty cell claim the item; later cells see it taken
	assign my_hit   = valid_q && (key_q == cmd.key);
	assign sel_hit  = my_hit && !hit_in;
	assign sel_free = !valid_q && !free_in;
	assign hit_out  = hit_in | my_hit;
	assign free_out = free_in | !valid_q;
	assign mask_out = mask_in | (sel_hit ? mask_q : '0);

	assign st = '{valid: valid_q, sel_hit: sel_hit_s1, sel_free: sel_free_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			sel_hit_s1  <= 1'b0;
			sel_free_s1 <= 1'b0;
		end else begin
			if (cmd.search) begin
				sel_hit_s1  <= sel_hit;
				sel_free_s1 <= sel_free;
			end
			if (cmd.clear_all) begin
				valid_q <= 1'b0;
			end else if (cmd.wr_new && sel_free_s1) begin
				valid_q <= 1'b1;
			end else if (cmd.del_hit && sel_hit_s1) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_new && sel_free_s1) begin
			key_q  <= cmd.key;
			mask_q <= cmd.mask;
		end else if (cmd.wr_hit && sel_hit_s1) begin
			mask_q <= cmd.mask;
		end
	end
endmodule
